// ===== rtl/chtk_pkg.sv =====
// Shared widths, codes and parameter defaults for the chained hash table.
`timescale 1ns / 1ps

package chtk_pkg;

	localparam int BUCKETS_DEF      = 10;
	localparam int BUCKET_DEPTH_DEF = 4;
	localparam int KEY_BITS_DEF     = 16;

	localparam int MODE_W   = 2;
	localparam int KEY_W    = 16;
	localparam int PAY_W    = 7;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 4;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 16;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

// ===== rtl/chtk_key_mod.sv =====
// Key modulo bucket count by reciprocal multiplication, two pipeline stages.
`timescale 1ns / 1ps

module chtk_key_mod #(
	parameter int KB      = 16,
	parameter int BUCKETS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KB-1:0] key,
	output logic          done,
	output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rem
);

	localparam int RW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SH = KB + $clog2(BUCKETS);
	localparam int MW = KB + 1;
	localparam int PW = KB + MW;
	localparam int XW = KB + RW + 1;
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];
	localparam logic [RW:0] TB = (RW + 1)'(BUCKETS);

	logic          v_s1;
	logic          v_s2;
	logic [KB-1:0] key_s1;
	logic [KB-1:0] key_s2;
	logic [KB-1:0] quo_s2;
	logic [PW-1:0] prod;
	logic [XW-1:0] back;

	// quotient = floor(key * ceil(2^SH / BUCKETS) / 2^SH), exact for KB-bit keys
	assign prod = PW'(key_s1) * PW'(RECIP_M);
	assign back = XW'(key_s2) - XW'(quo_s2) * XW'(TB);
	assign done = v_s2;
	assign rem  = back[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_s1 <= key;
		end
		if (v_s1) begin
			key_s2 <= key_s1;
			quo_s2 <= KB'(prod >> SH);
		end
	end

`ifndef ASSERT_OFF
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(rem) < BUCKETS))
		else $error("bucket remainder out of range");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> !start)
		else $error("modulo restarted while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("modulo done held for two cycles");
`endif

endmodule

// ===== rtl/chained_hash_table_by_key.sv =====
// Top level: bucketed key table with insert, search and delete by key.
//
//  channel  dir  fields
//  s_axis   in   tdata: key[15:0], payload[22:16]; tuser: mode[1:0]
//  m_axis   out  tdata: bucket_index[3:0], found_payload[10:4]; tuser: status[1:0]
//
// An item passes from accept to result through the modulo unit (reciprocal
// multiply, then remainder), a read of the bucket row and fill count, and an update.
// After reset a clearing pass zeroes the fill count of every bucket, s_axis held off.
// A result waits in the output register; the update stalls only while it is still
// held and m_axis_tready is low. A new beat is taken while a result is waiting.
`timescale 1ns / 1ps

module chained_hash_table_by_key
	import chtk_pkg::*;
#(
	parameter int BUCKETS      = BUCKETS_DEF,
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
	parameter int KEY_BITS     = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // key, payload
	input  logic [MODE_W-1:0]   s_axis_tuser,  // mode
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // bucket_index, found_payload
	output logic [STATUS_W-1:0] m_axis_tuser   // status
);

	localparam int KB     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int FW     = $clog2(BUCKET_DEPTH + 1);
	localparam int SW     = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int SLOT_W = KB + PAY_W;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HASH  = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0] state_q;
	logic [BW-1:0] clr_q;
	logic [BW-1:0] bucket_q;
	logic [MODE_W-1:0] mode_q;
	logic [KB-1:0] key_q;
	logic [PAY_W-1:0] pay_q;

	logic [BUCKET_DEPTH-1:0][SLOT_W-1:0] row_mem [BUCKETS];
	logic [FW-1:0] fill_mem [BUCKETS];
	logic [BUCKET_DEPTH-1:0][SLOT_W-1:0] row_rd_q;
	logic [FW-1:0] fill_rd_q;

	logic m_valid_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [IDX_W-1:0] m_idx_q;
	logic [PAY_W-1:0] m_pay_q;

	logic accept;
	logic mod_done;
	logic [BW-1:0] mod_rem;
	logic rd_en;
	logic exec_go;

	logic [BUCKET_DEPTH-1:0][SLOT_W-1:0] row_wr;
	logic row_we;
	logic fill_we;
	logic [BW-1:0] fill_wa;
	logic [FW-1:0] fill_wd;
	logic [STATUS_W-1:0] status_nx;
	logic [PAY_W-1:0] found_nx;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign rd_en         = (state_q == S_HASH) && mod_done;
	assign exec_go       = (state_q == S_EXEC) && (!m_valid_q || m_axis_tready);

	chtk_key_mod #(
		.KB      (KB),
		.BUCKETS (BUCKETS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (s_axis_tdata[KB-1:0]),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	always_comb begin
		logic [BUCKET_DEPTH-1:0] hit;
		logic                    found;
		logic [SW-1:0]           hs;
		logic                    full;
		hs = '0;
		found = 1'b0;
		for (int s = 0; s < BUCKET_DEPTH; s++) begin
			hit[s] = (FW'(s) < fill_rd_q) && (row_rd_q[s][KB-1:0] == key_q);
		end
		for (int s = BUCKET_DEPTH - 1; s >= 0; s--) begin
			if (hit[s]) begin
				hs = SW'(s);
				found = 1'b1;
			end
		end
		full = (fill_rd_q >= FW'(BUCKET_DEPTH));

		row_wr    = row_rd_q;
		row_we    = 1'b0;
		status_nx = STATUS_MISS;
		found_nx  = '0;
		fill_wd   = fill_rd_q;
		case (mode_q)
			MODE_INSERT: begin
				if (full) begin
					status_nx = STATUS_FULL;
				end else begin
					status_nx = STATUS_OK;
					row_we    = 1'b1;
					fill_wd   = fill_rd_q + 1'b1;
					for (int s = 0; s < BUCKET_DEPTH; s++) begin
						if (FW'(s) == fill_rd_q) begin
							row_wr[s] = {pay_q, key_q};
						end
					end
				end
			end
			MODE_SEARCH: begin
				if (found) begin
					status_nx = STATUS_OK;
					found_nx  = row_rd_q[hs][SLOT_W-1:KB];
				end
			end
			MODE_DELETE: begin
				if (found) begin
					status_nx = STATUS_OK;
					row_we    = 1'b1;
					fill_wd   = fill_rd_q - 1'b1;
					for (int s = 0; s < BUCKET_DEPTH - 1; s++) begin
						if (SW'(s) >= hs) begin
							row_wr[s] = row_rd_q[s + 1];
						end
					end
				end
			end
			default: begin
				status_nx = STATUS_MISS;
			end
		endcase

		if (state_q == S_CLEAR) begin
			fill_we = 1'b1;
			fill_wa = clr_q;
			fill_wd = '0;
		end else begin
			fill_we = exec_go && row_we;
			fill_wa = bucket_q;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && row_we) begin
			row_mem[bucket_q] <= row_wr;
		end
		if (rd_en) begin
			row_rd_q <= row_mem[mod_rem];
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_wa] <= fill_wd;
		end
		if (rd_en) begin
			fill_rd_q <= fill_mem[mod_rem];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_axis_tuser;
			key_q  <= s_axis_tdata[KB-1:0];
			pay_q  <= s_axis_tdata[KEY_W +: PAY_W];
		end
		if (rd_en) begin
			bucket_q <= mod_rem;
		end
		if (exec_go) begin
			m_status_q <= status_nx;
			m_idx_q    <= IDX_W'(bucket_q);
			m_pay_q    <= found_nx;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = M_DATA_W'({m_pay_q, m_idx_q});

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> (fill_wd <= FW'(BUCKET_DEPTH)))
		else $error("bucket fill written past depth");
	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_HASH))
		else $error("key modulo finished outside hash state");
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go && (status_nx == STATUS_FULL) |-> (fill_rd_q == FW'(BUCKET_DEPTH)))
		else $error("full status on a bucket with room");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> m_valid_q && (state_q == S_IDLE))
		else $error("update did not load the result register");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the chained hash table: directed and random insert/search/delete and unused-mode beats.
`timescale 1ns / 1ps

module testbench;
	import chtk_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int SLOTS       = BUCKETS_DEF * BUCKET_DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int N_RANDOM    = 1400;
	localparam int POOL_SIZE   = 32;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    bucket;
		logic [PAY_W-1:0]    payload;
	} lookup_t;

	class table_scoreboard;
		logic [2:0]       fill [BUCKETS_DEF];
		logic [KEY_W-1:0] slot_key [SLOTS];
		logic [PAY_W-1:0] slot_pay [SLOTS];
		lookup_t          pending [$];
		int               mismatches;

		function new();
			foreach (fill[i]) fill[i] = '0;
			mismatches = 0;
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		function void flag(string what);
			if (mismatches < 10)
				$display("%0t mismatch: %s", $realtime, what);
			mismatches++;
		endfunction

		// Earliest slot holding k in bucket b, -1 if none.
		function int locate(int b, logic [KEY_W-1:0] k);
			for (int s = 0; s < fill[b]; s++)
				if (slot_key[b*BUCKET_DEPTH_DEF + s] == k)
					return s;
			return -1;
		endfunction

		function void note_input(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] k,
				logic [PAY_W-1:0] pay);
			lookup_t r;
			int b;
			int s;
			int n;
			b = k % BUCKETS_DEF;
			r.status  = STATUS_MISS;
			r.bucket  = b[IDX_W-1:0];
			r.payload = '0;
			n = fill[b];
			case (mode)
				MODE_INSERT: begin
					if (n >= BUCKET_DEPTH_DEF) begin
						r.status = STATUS_FULL;
					end else begin
						slot_key[b*BUCKET_DEPTH_DEF + n] = k;
						slot_pay[b*BUCKET_DEPTH_DEF + n] = pay;
						fill[b] = 3'(n + 1);
						r.status = STATUS_OK;
					end
				end
				MODE_SEARCH: begin
					s = locate(b, k);
					if (s >= 0) begin
						r.status  = STATUS_OK;
						r.payload = slot_pay[b*BUCKET_DEPTH_DEF + s];
					end
				end
				MODE_DELETE: begin
					s = locate(b, k);
					if (s >= 0) begin
						for (int i = s; i + 1 < n; i++) begin
							slot_key[b*BUCKET_DEPTH_DEF + i] = slot_key[b*BUCKET_DEPTH_DEF + i + 1];
							slot_pay[b*BUCKET_DEPTH_DEF + i] = slot_pay[b*BUCKET_DEPTH_DEF + i + 1];
						end
						fill[b] = 3'(n - 1);
						r.status = STATUS_OK;
					end
				end
				default: ;
			endcase
			pending = {pending, r};
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] bucket,
				logic [PAY_W-1:0] pay);
			lookup_t e;
			if (pending.size() == 0) begin
				flag($sformatf("unexpected beat status=%0d bucket=%0d payload=%0d",
					status, bucket, pay));
				return;
			end
			e = pending.pop_front();
			if (status !== e.status)
				flag($sformatf("status exp %0d got %0d", e.status, status));
			if (bucket !== e.bucket)
				flag($sformatf("bucket exp %0d got %0d", e.bucket, bucket));
			if (pay !== e.payload)
				flag($sformatf("payload exp %0d got %0d", e.payload, pay));
		endfunction

		function void drain_check();
			while (pending.size() != 0) begin
				void'(pending.pop_front());
				flag("result never arrived");
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;  // key[15:0], payload[22:16]
	logic [MODE_W-1:0]   s_axis_tuser = '0;  // mode
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;       // bucket_index[3:0], found_payload[10:4]
	logic [STATUS_W-1:0] m_axis_tuser;       // status

	table_scoreboard sb = new();
	bit              no_idle = 1'b0;
	int              idle_cycles = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	chained_hash_table_by_key dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic send_beat(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] k,
			logic [PAY_W-1:0] pay);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {1'b0, pay, k};
		s_axis_tuser  <= mode;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		int r;
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  k;
		r = $urandom_range(0, 99);
		if (r < 40)
			mode = MODE_INSERT;
		else if (r < 70)
			mode = MODE_SEARCH;
		else if (r < 95)
			mode = MODE_DELETE;
		else
			mode = MODE_UNUSED;
		if ($urandom_range(0, 9) == 0)
			k = KEY_W'($urandom_range(0, 65535));
		else
			k = key_pool[$urandom_range(0, POOL_SIZE-1)];
		send_beat(mode, k, PAY_W'($urandom_range(0, 127)));
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[10:4]);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[22:16]);
		end
	end

	// sink backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !no_idle) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = 0;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL chained_hash_table_by_key");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, duplicates, full bucket, shifting delete, unused mode
		send_beat(MODE_INSERT, 16'd0, 7'd0);
		send_beat(MODE_INSERT, 16'hFFFF, 7'h7F);
		send_beat(MODE_SEARCH, 16'hFFFF, 7'd0);
		send_beat(MODE_SEARCH, 16'd0, 7'h7F);
		send_beat(MODE_SEARCH, 16'd10, 7'd0);
		send_beat(MODE_DELETE, 16'd20, 7'd0);
		send_beat(MODE_INSERT, 16'd15, 7'd1);
		send_beat(MODE_INSERT, 16'hFFFF, 7'd2);
		send_beat(MODE_INSERT, 16'd25, 7'd3);
		send_beat(MODE_INSERT, 16'd35, 7'd4);
		send_beat(MODE_SEARCH, 16'hFFFF, 7'd0);
		send_beat(MODE_DELETE, 16'hFFFF, 7'd0);
		send_beat(MODE_SEARCH, 16'hFFFF, 7'd0);
		send_beat(MODE_SEARCH, 16'd25, 7'd0);
		send_beat(MODE_UNUSED, 16'hAAAA, 7'h55);
		send_beat(MODE_UNUSED, 16'h5555, 7'h2A);
		send_beat(MODE_DELETE, 16'd0, 7'd0);
		send_beat(MODE_DELETE, 16'd0, 7'd0);
		send_beat(MODE_SEARCH, 16'd0, 7'd0);
		send_beat(MODE_INSERT, 16'd35, 7'h7F);
		send_beat(MODE_INSERT, 16'd45, 7'h11);
		send_beat(MODE_DELETE, 16'd25, 7'd0);
		send_beat(MODE_SEARCH, 16'd35, 7'd0);
		send_beat(MODE_SEARCH, 16'd7, 7'h7F);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 200 == 0)
				foreach (key_pool[j])
					key_pool[j] = KEY_W'($urandom_range(0, 65535));
			if (i == 700) begin
				s_axis_tvalid <= 1'b0;
				while (sb.outstanding() != 0)
					@(posedge clk);
				@(negedge clk);
			end
			no_idle = (i >= 900 && i < 1000);
			send_random();
		end
		s_axis_tvalid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		sb.drain_check();
		if (sb.mismatches == 0)
			$display("PASS chained_hash_table_by_key");
		else
			$display("FAIL chained_hash_table_by_key");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/chtk_pkg.sv
rtl/chtk_key_mod.sv
rtl/chained_hash_table_by_key.sv
tb/testbench.sv
